>>> rtl/bra_pkg.sv
package bra_pkg;

  // Store geometry
  localparam int MAP_BITS    = 4096;
  localparam int WORD_BITS   = 64;
  localparam int STORE_WORDS = MAP_BITS / WORD_BITS;
  localparam int WA_W        = $clog2(STORE_WORDS);
  localparam int BO_W        = $clog2(WORD_BITS);

  // The find scan looks at one chunk of a word per cycle, pausing to read each new word.
  localparam int CHUNK_BITS  = 8;
  localparam int CK_W        = $clog2(CHUNK_BITS);
  localparam int CH_W        = BO_W - CK_W;

  // Field widths
  localparam int IDX_W = 12;
  localparam int LEN_W = 13;
  localparam int CAP_W = 13;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAP_BITS);

  typedef enum logic [1:0] {
    OP_FIND      = 2'd0,
    OP_SET_RANGE = 2'd1,
    OP_TEST      = 2'd2,
    OP_SET_BIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_RANGE     = 2'd2
  } sts_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRD,
    S_SCAN,
    S_RRD,
    S_RLD,
    S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;
    logic f_rd;
    logic scan;
    logic r_rd;
    logic r_ld;
    logic finish;
  } ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic imm_done;
    logic is_find;
    logic scan_nf;
    logic scan_found;
    logic scan_inv;
    logic chunk_last;
    logic range_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/bra_ram.sv
module bra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bra_ctrl.sv
module bra_ctrl import bra_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (sts.imm_done) begin
            state_nxt = S_DONE;
          end else if (sts.is_find) begin
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_RRD;
          end
        end
      end
      S_FRD: begin
        ctl.f_rd  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_nf) begin
          state_nxt = S_DONE;
        end else if (sts.scan_found) begin
          state_nxt = sts.scan_inv ? S_RRD : S_DONE;
        end else if (sts.chunk_last) begin
          state_nxt = S_FRD;
        end
      end
      S_RRD: begin
        ctl.r_rd  = 1'b1;
        state_nxt = S_RLD;
      end
      S_RLD: begin
        ctl.r_ld  = 1'b1;
        state_nxt = sts.range_last ? S_DONE : S_RRD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bra_dp.sv
module bra_dp import bra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  output sts_t             sts,
  input  logic [1:0]       in_operation,
  input  logic [IDX_W-1:0] in_position,
  input  logic [LEN_W-1:0] in_run_length,
  input  logic             in_bit_value,
  input  logic             in_invert_run,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_result_index,
  output logic [1:0]       out_status,
  output logic             out_test_match
);

  logic [CAP_W-1:0]   cap_r;
  logic [CAP_W-1:0]   cap;
  op_t                op_r;
  logic [IDX_W-1:0]   pos_r;
  logic [LEN_W-1:0]   len_r;
  logic               v_r;
  logic               inv_r;
  logic [WA_W-1:0]    w_r;
  logic [CH_W-1:0]    c_r;
  logic [LEN_W-1:0]   run_r;
  logic [IDX_W-1:0]   start_r;
  logic [IDX_W-1:0]   lo_r;
  logic [LEN_W-1:0]   hi_r;
  logic               wv_r;
  logic               set_r;
  logic               mis_r;
  logic [1:0]         stat_r;
  logic [IDX_W-1:0]   idx_r;
  logic [STORE_WORDS-1:0] valid_r;
  logic               vq_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [1:0]         out_stat_r;
  logic               out_match_r;

  logic [WORD_BITS-1:0] ram_q;
  logic [WORD_BITS-1:0] word;
  logic                 ram_re;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] new_word;
  logic                 word_mis;
  logic [LEN_W:0]       pos_end;
  logic                 imm_err;
  logic                 imm_nf;
  logic [LEN_W-1:0]     hi_last;
  logic [IDX_W-1:0]     chunk_base;
  logic                 chunk_oob;
  logic                 store_last;
  logic [LEN_W-1:0]     run_v;
  logic [IDX_W-1:0]     start_v;
  logic                 fnd_v;
  logic [IDX_W-1:0]     bi;
  logic [LEN_W-1:0]     idx13;

  // Effective capacity: rounded down to a byte and saturated at the store size.
  always_comb begin
    cap = {cap_r[CAP_W-1:3], 3'b000};
    if (cap > CAP_W'(MAP_BITS)) begin
      cap = CAP_W'(MAP_BITS);
    end
  end

  // Request checks that finish without touching the store.
  always_comb begin
    pos_end = {2'b00, in_position} + {1'b0, in_run_length};
    imm_err = 1'b0;
    imm_nf  = 1'b0;
    if (op_t'(in_operation) == OP_SET_BIT) begin
      imm_err = ({1'b0, in_position} >= cap);
    end else if (in_run_length == '0) begin
      imm_err = 1'b1;
    end else if (op_t'(in_operation) == OP_FIND) begin
      imm_nf = ({1'b0, in_position} >= cap);
    end else begin
      imm_err = (pos_end > {1'b0, cap});
    end
  end

  // Store word as read; rows never written read as zero.
  assign word      = vq_r ? ram_q : '0;
  assign ram_re    = ctl.f_rd | ctl.r_rd;
  assign ram_raddr = w_r;

  bra_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_WORDS)) u_ram (
    .clk   (clk),
    .we    (ctl.r_ld & set_r),
    .waddr (w_r),
    .wdata (new_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // One chunk of the find scan: run tracking over eight bits.
  always_comb begin
    chunk_base = {w_r, c_r, CK_W'(0)};
    chunk_oob  = ({1'b0, chunk_base} >= cap);
    store_last = (w_r == '1) && (c_r == '1);
    run_v      = run_r;
    start_v    = start_r;
    fnd_v      = 1'b0;
    bi         = '0;
    for (int k = 0; k < CHUNK_BITS; k++) begin
      bi = {w_r, c_r, CK_W'(k)};
      if (!fnd_v && (bi >= pos_r)) begin
        if (word[{c_r, CK_W'(k)}] == v_r) begin
          if (run_v == '0) begin
            start_v = bi;
          end
          run_v = run_v + 1'b1;
          if (run_v >= len_r) begin
            fnd_v = 1'b1;
          end
        end else begin
          run_v = '0;
        end
      end
    end
  end

  // Range mask for the current word, and the modified word.
  always_comb begin
    mask  = '0;
    idx13 = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx13   = {1'b0, w_r, BO_W'(j)};
      mask[j] = (idx13 >= {1'b0, lo_r}) && (idx13 < hi_r);
    end
    new_word = (word & ~mask) | (mask & {WORD_BITS{wv_r}});
    word_mis = |((word ^ {WORD_BITS{wv_r}}) & mask);
    hi_last  = hi_r - 1'b1;
  end

  always_comb begin
    sts            = '0;
    sts.imm_done   = imm_err | imm_nf;
    sts.is_find    = (op_t'(in_operation) == OP_FIND);
    sts.scan_nf    = chunk_oob | (!fnd_v & store_last);
    sts.scan_found = fnd_v;
    sts.scan_inv   = inv_r;
    sts.chunk_last = (c_r == '1);
    sts.range_last = (w_r == hi_last[IDX_W-1:BO_W]);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (ctl.r_ld && set_r) begin
        valid_r[w_r] <= 1'b1;
      end
      if (ctl.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      vq_r <= valid_r[ram_raddr];
    end
    if (ctl.accept) begin
      op_r    <= op_t'(in_operation);
      pos_r   <= in_position;
      len_r   <= in_run_length;
      v_r     <= in_bit_value;
      inv_r   <= in_invert_run;
      w_r     <= in_position[IDX_W-1:BO_W];
      c_r     <= in_position[BO_W-1:CK_W];
      run_r   <= '0;
      start_r <= '0;
      lo_r    <= in_position;
      hi_r    <= (op_t'(in_operation) == OP_SET_BIT) ?
                 {1'b0, in_position} + 1'b1 : pos_end[LEN_W-1:0];
      wv_r    <= in_bit_value;
      set_r   <= (op_t'(in_operation) != OP_TEST);
      mis_r   <= 1'b0;
      idx_r   <= '0;
      stat_r  <= imm_err ? STS_RANGE : (imm_nf ? STS_NOT_FOUND : STS_OK);
    end
    if (ctl.scan) begin
      run_r   <= run_v;
      start_r <= start_v;
      if (sts.scan_nf) begin
        stat_r <= STS_NOT_FOUND;
      end else if (fnd_v) begin
        idx_r <= start_v;
        lo_r  <= start_v;
        hi_r  <= {1'b0, start_v} + len_r;
        wv_r  <= !v_r;
        set_r <= 1'b1;
        w_r   <= start_v[IDX_W-1:BO_W];
      end else begin
        c_r <= c_r + 1'b1;
        if (c_r == '1) begin
          w_r <= w_r + 1'b1;
        end
      end
    end
    if (ctl.r_ld) begin
      mis_r <= mis_r | word_mis;
      w_r   <= w_r + 1'b1;
    end
    if (ctl.finish) begin
      out_idx_r   <= idx_r;
      out_stat_r  <= stat_r;
      out_match_r <= (op_r == OP_TEST) && (stat_r == STS_OK) && !mis_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_stat_r;
  assign out_test_match   = out_match_r;

endmodule

>>> rtl/bitmap_run_allocator_core.sv
// Bitmap run allocator over a 4096-bit store held as 64 words of 64 bits in
// one RAM. Requests are taken one at a time; each gives exactly one result
// beat. Requests refused at the door (zero length, range past capacity, find
// start past capacity, bit past capacity) finish without touching the store.
// Set bit, set range and test range visit each store word touched in turn, a
// registered RAM read followed by a read-modify-write (test only compares).
// Find reads each word reached and scans it in 8-bit chunks, then, when the
// run is flipped, visits each word of the found run the same way as set
// range. Rows never written read as zero, tracked by one valid flip-flop per
// row, so no clearing pass follows reset. The user must write capacity
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module bitmap_run_allocator_core import bra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [IDX_W-1:0] in_position,
  input  logic [LEN_W-1:0] in_run_length,
  input  logic             in_bit_value,
  input  logic             in_invert_run,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_result_index,
  output logic [1:0]       out_status,
  output logic             out_test_match,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  ctl_t ctl;
  sts_t sts;
  logic busy;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .ctl      (ctl),
    .busy     (busy)
  );

  bra_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_run_length    (in_run_length),
    .in_bit_value     (in_bit_value),
    .in_invert_run    (in_invert_run),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_test_match   (out_test_match)
  );

  assign in_stall = busy;

  // An accepted request keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a request");

  // A result only issues while a request is in flight.
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> busy)
    else $error("result issued with no request in flight");

  // A failed request never reports a match.
  a_match_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STS_OK)) |-> !out_test_match)
    else $error("test match reported on a failed request");

  // A not-found result carries index zero.
  a_nf_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_NOT_FOUND)) |-> (out_result_index == '0))
    else $error("nonzero index on a not-found result");

endmodule
